// ===== hw/rtl/sfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg: settings frame parser shared definitions
// Character codes, frame geometry, reset settings and the reply command type.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int unsigned SFP_FRAME_LEN = 18;
	localparam int unsigned SFP_HIST_LEN  = SFP_FRAME_LEN - 1;
	localparam int unsigned SFP_SPLIT_POS = 13;
	localparam int unsigned SFP_ACK_LEN   = 3;
	localparam int unsigned SFP_FILL_W    = $clog2(SFP_HIST_LEN + 1);
	localparam int unsigned SFP_IDX_W     = $clog2(SFP_FRAME_LEN);
	localparam int unsigned SFP_Q_DEPTH   = 4;

	localparam logic [7:0] SFP_CH_HASH   = 8'h23;
	localparam logic [7:0] SFP_CH_DOLLAR = 8'h24;
	localparam logic [7:0] SFP_CH_QUERY  = 8'h3F;
	localparam logic [7:0] SFP_CH_ZERO   = 8'h30;
	localparam logic [7:0] SFP_CH_NINE   = 8'h39;
	localparam logic [7:0] SFP_CH_A      = 8'h41;
	localparam logic [7:0] SFP_CH_C      = 8'h43;
	localparam logic [7:0] SFP_CH_K      = 8'h4B;

	localparam logic [7:0] SFP_RST_ADDR0 = 8'd192;
	localparam logic [7:0] SFP_RST_ADDR1 = 8'd168;
	localparam logic [7:0] SFP_RST_ADDR2 = 8'd1;
	localparam logic [7:0] SFP_RST_ADDR3 = 8'd137;
	localparam logic [9:0] SFP_RST_DEV   = 10'd999;
	localparam logic [9:0] SFP_DEV_MAX   = 10'd999;

	// one queued reply: kind and the settings it reports
	typedef struct packed {
		logic            report;
		logic [3:0][7:0] addr;
		logic [9:0]      dev;
	} sfp_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sfp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_if: settings frame parser channels
// Receive byte channel and reply byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink   (input valid, input rx_char, output ready);
endinterface

interface sfp_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_char;
	logic       run_end;
	logic       reply_kind;
	logic       save_request;
	logic [7:0] addr_first;
	logic [7:0] addr_second;
	logic [7:0] addr_third;
	logic [7:0] addr_fourth;
	logic [9:0] device_number;

	modport source (output valid, output tx_char, output run_end, output reply_kind,
		output save_request, output addr_first, output addr_second, output addr_third,
		output addr_fourth, output device_number, input ready);
	modport sink (input valid, input tx_char, input run_end, input reply_kind,
		input save_request, input addr_first, input addr_second, input addr_third,
		input addr_fourth, input device_number, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sfp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_front: receive window and frame classifier
// Shifts received bytes into a 17-byte window, matches settings frames and
// queries, updates the settings store and queues reply commands.
// ----------------------------------------------------------------------------
module sfp_front import sfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	sfp_rx_if.sink   rx,
	input  logic     q_full,
	output logic     push,
	output sfp_cmd_t cmd
);

	logic [7:0]            recent_q [SFP_HIST_LEN];
	logic [SFP_FILL_W-1:0] fill_q;
	logic [3:0][7:0]       addr_q;
	logic [9:0]            dev_q;

	logic            accept;
	logic            frame_hit;
	logic            query_hit;
	logic [3:0][7:0] new_addr;
	logic [9:0]      new_dev;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= SFP_CH_ZERO) && (c <= SFP_CH_NINE);
	endfunction

	// decimal group of up to three digits, ends at first non-digit
	function automatic logic [9:0] rd_group(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2);
		logic [9:0] d0;
		logic [9:0] d1;
		logic [9:0] d2;
		d0 = {6'd0, c0[3:0]};
		d1 = {6'd0, c1[3:0]};
		d2 = {6'd0, c2[3:0]};
		if (!is_digit(c0)) begin
			return 10'd0;
		end else if (!is_digit(c1)) begin
			return d0;
		end else if (!is_digit(c2)) begin
			return 10'(d0 * 10'd10) + d1;
		end else begin
			return 10'(d0 * 10'd100) + 10'(d1 * 10'd10) + d2;
		end
	endfunction

	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;

	assign frame_hit = (fill_q == SFP_FILL_W'(SFP_HIST_LEN)) &&
		(recent_q[0] == SFP_CH_HASH) && (recent_q[SFP_SPLIT_POS] == SFP_CH_DOLLAR) &&
		(rx.rx_char == SFP_CH_HASH);
	assign query_hit = (fill_q != '0) && (recent_q[SFP_HIST_LEN-1] == SFP_CH_HASH) &&
		(rx.rx_char == SFP_CH_QUERY);

	always_comb begin
		logic [9:0] g;
		for (int k = 0; k < 4; k++) begin
			g = rd_group(recent_q[1+3*k], recent_q[2+3*k], recent_q[3+3*k]);
			new_addr[k] = g[7:0];
		end
		new_dev = rd_group(recent_q[SFP_SPLIT_POS+1], recent_q[SFP_SPLIT_POS+2],
			recent_q[SFP_SPLIT_POS+3]);
	end

	assign push       = accept && (frame_hit || query_hit);
	assign cmd.report = !frame_hit;
	assign cmd.addr   = frame_hit ? new_addr : addr_q;
	assign cmd.dev    = frame_hit ? new_dev : dev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SFP_HIST_LEN; i++) begin
				recent_q[i] <= '0;
			end
			fill_q    <= '0;
			addr_q[0] <= SFP_RST_ADDR0;
			addr_q[1] <= SFP_RST_ADDR1;
			addr_q[2] <= SFP_RST_ADDR2;
			addr_q[3] <= SFP_RST_ADDR3;
			dev_q     <= SFP_RST_DEV;
		end else if (accept) begin
			for (int i = 0; i < SFP_HIST_LEN - 1; i++) begin
				recent_q[i] <= recent_q[i+1];
			end
			recent_q[SFP_HIST_LEN-1] <= rx.rx_char;
			if (fill_q != SFP_FILL_W'(SFP_HIST_LEN)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (frame_hit) begin
				addr_q <= new_addr;
				dev_q  <= new_dev;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sfp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_queue: reply command queue
// Small FIFO between the classifier and the reply generator.
// ----------------------------------------------------------------------------
module sfp_queue import sfp_pkg::*; #(
	parameter int unsigned DEPTH = SFP_Q_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sfp_cmd_t din,
	output logic     full,
	output logic     valid,
	output sfp_cmd_t dout,
	input  logic     pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sfp_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sfp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_back: reply byte generator
// Expands each queued command into an ACK run or a settings report run,
// one byte per transfer, through a registered output stage.
// ----------------------------------------------------------------------------
module sfp_back import sfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  sfp_cmd_t q_cmd,
	output logic     q_pop,
	sfp_tx_if.source tx
);

	logic [SFP_IDX_W-1:0] idx_q;
	logic                 ovalid_q;
	logic [7:0]           char_q;
	logic                 last_q;
	logic                 kind_q;
	logic [3:0][7:0]      addr_q;
	logic [9:0]           dev_q;

	logic       load;
	logic       last;
	logic [9:0] val;
	logic [1:0] pos;
	logic [3:0] digit;
	logic [7:0] rep_char;
	logic [7:0] ack_char;

	// three decimal digits of a value below 1000, hundreds first
	function automatic logic [2:0][3:0] dec3(input logic [9:0] v);
		logic [3:0] h;
		logic [3:0] t;
		logic [9:0] r;
		h = '0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 10'(i * 100)) begin
				h = 4'(i);
			end
		end
		r = v - 10'({6'd0, h} * 10'd100);
		t = '0;
		for (int i = 1; i < 10; i++) begin
			if (r >= 10'(i * 10)) begin
				t = 4'(i);
			end
		end
		r = r - 10'({6'd0, t} * 10'd10);
		return {h, t, r[3:0]};
	endfunction

	always_comb begin
		logic [2:0][3:0] dg;
		unique case (idx_q) inside
			5'd1, 5'd2, 5'd3:    val = {2'b00, q_cmd.addr[0]};
			5'd4, 5'd5, 5'd6:    val = {2'b00, q_cmd.addr[1]};
			5'd7, 5'd8, 5'd9:    val = {2'b00, q_cmd.addr[2]};
			5'd10, 5'd11, 5'd12: val = {2'b00, q_cmd.addr[3]};
			default:             val = q_cmd.dev;
		endcase
		unique case (idx_q) inside
			5'd1, 5'd4, 5'd7, 5'd10, 5'd14: pos = 2'd2;
			5'd2, 5'd5, 5'd8, 5'd11, 5'd15: pos = 2'd1;
			default:                        pos = 2'd0;
		endcase
		dg    = dec3(val);
		digit = dg[pos];
		if (idx_q == '0 || idx_q == SFP_IDX_W'(SFP_FRAME_LEN - 1)) begin
			rep_char = SFP_CH_HASH;
		end else if (idx_q == SFP_IDX_W'(SFP_SPLIT_POS)) begin
			rep_char = SFP_CH_DOLLAR;
		end else begin
			rep_char = SFP_CH_ZERO + {4'd0, digit};
		end
		unique case (idx_q)
			5'd0:    ack_char = SFP_CH_A;
			5'd1:    ack_char = SFP_CH_C;
			default: ack_char = SFP_CH_K;
		endcase
	end

	assign last  = q_cmd.report ? (idx_q == SFP_IDX_W'(SFP_FRAME_LEN - 1))
		: (idx_q == SFP_IDX_W'(SFP_ACK_LEN - 1));
	assign load  = q_valid && (!ovalid_q || tx.ready);
	assign q_pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			ovalid_q <= 1'b1;
			idx_q    <= last ? '0 : idx_q + 1'b1;
		end else if (tx.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= q_cmd.report ? rep_char : ack_char;
			last_q <= last;
			kind_q <= q_cmd.report;
			addr_q <= q_cmd.addr;
			dev_q  <= q_cmd.dev;
		end
	end

	assign tx.valid         = ovalid_q;
	assign tx.tx_char       = char_q;
	assign tx.run_end       = last_q;
	assign tx.reply_kind    = kind_q;
	assign tx.save_request  = !kind_q;
	assign tx.addr_first    = addr_q[0];
	assign tx.addr_second   = addr_q[1];
	assign tx.addr_third    = addr_q[2];
	assign tx.addr_fourth   = addr_q[3];
	assign tx.device_number = dev_q;

endmodule
`default_nettype wire

// ===== hw/rtl/settings_frame_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// settings_frame_parser_top: byte-serial settings frame parser
// Matches settings frames and queries on a received byte stream and replies.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle as long as the reply queue (Q_DEPTH
// commands) has room. A frame "#dddddddddddd$ddd#" loads four address bytes
// and a device number and queues an ACK run of 3 bytes; "#?" queues a report
// run of 18 bytes. The reply generator sends one byte per transfer, and input
// stalls only when Q_DEPTH replies are pending. The first reply byte is
// registered in the reply queue and then in the output stage.
module settings_frame_parser_top import sfp_pkg::*; #(
	parameter int unsigned Q_DEPTH = SFP_Q_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	sfp_rx_if.sink   rx,
	sfp_tx_if.source tx
);

	logic     push;
	logic     q_full;
	logic     q_valid;
	logic     q_pop;
	sfp_cmd_t push_cmd;
	sfp_cmd_t head_cmd;

	sfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	sfp_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (q_full),
		.valid  (q_valid),
		.dout   (head_cmd),
		.pop    (q_pop)
	);

	sfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (head_cmd),
		.q_pop   (q_pop),
		.tx      (tx)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("reply command pushed into full queue");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("reply queue popped while empty");

	a_ack_ends_on_k: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.run_end && !tx.reply_kind) |-> (tx.tx_char == SFP_CH_K))
		else $error("ACK run does not end on K");

	a_dev_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> (tx.device_number <= SFP_DEV_MAX))
		else $error("device number out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: settings frame parser testbench
// Streams received bytes into settings_frame_parser_top. The stream holds
// settings frames, queries, frames that share their closing hash, broken
// frames and noise, and both channels idle at random. A local model of the
// parser predicts every reply byte. Each reply transfer is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfp_pkg::*;

	typedef enum logic {
		KIND_ACK    = 1'b0,
		KIND_REPORT = 1'b1
	} reply_kind_e;

	typedef struct packed {
		logic [7:0]      ch;
		logic            last;
		reply_kind_e     kind;
		logic            save;
		logic [3:0][7:0] addr;
		logic [9:0]      dev;
	} reply_beat_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       hold;
	} rx_item_t;

	typedef logic [7:0] frame_t [SFP_FRAME_LEN];

	logic clk;
	logic arst_n;

	sfp_rx_if rx_if ();
	sfp_tx_if tx_if ();

	settings_frame_parser_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	// parser model state
	logic [7:0]      recent_rx [SFP_HIST_LEN];
	int unsigned     rx_depth;
	logic [3:0][7:0] addr_now;
	logic [9:0]      dev_now;

	reply_beat_t reply_due [$];
	rx_item_t    rx_backlog [$];
	bit          hold_next;
	int unsigned mismatches;

	int unsigned rx_gap;
	bit          rx_burst;
	int unsigned tx_stall;
	int unsigned tx_draw;
	bit          tx_burst;
	reply_beat_t seen;

	function automatic int unsigned group_value(input frame_t f, input int unsigned start);
		int unsigned acc;
		int unsigned k;
		acc = 0;
		for (k = 0; k < 3; k++) begin
			if (f[start + k] < SFP_CH_ZERO || f[start + k] > SFP_CH_NINE)
				break;
			acc = acc * 10 + (f[start + k] - SFP_CH_ZERO);
		end
		return acc;
	endfunction

	function automatic logic [2:0][7:0] decimal_text(input int unsigned v);
		decimal_text[2] = SFP_CH_ZERO + 8'((v / 100) % 10);
		decimal_text[1] = SFP_CH_ZERO + 8'((v / 10) % 10);
		decimal_text[0] = SFP_CH_ZERO + 8'(v % 10);
	endfunction

	function automatic void push_beat(input logic [7:0] ch, input logic last,
		input reply_kind_e kind, input logic save);
		reply_beat_t b;
		b.ch   = ch;
		b.last = last;
		b.kind = kind;
		b.save = save;
		b.addr = addr_now;
		b.dev  = dev_now;
		reply_due.push_back(b);
	endfunction

	// advance the parser model by one received byte and queue its replies
	function automatic void parse_rx_byte(input logic [7:0] cur);
		frame_t          frm;
		frame_t          rep;
		logic [2:0][7:0] txt;
		int unsigned     k;
		int unsigned     j;
		for (k = 0; k < SFP_HIST_LEN; k++)
			frm[k] = recent_rx[k];
		frm[SFP_FRAME_LEN - 1] = cur;
		if (rx_depth >= SFP_HIST_LEN && frm[0] == SFP_CH_HASH &&
			frm[SFP_SPLIT_POS] == SFP_CH_DOLLAR && cur == SFP_CH_HASH) begin
			for (k = 0; k < 4; k++)
				addr_now[k] = 8'(group_value(frm, 1 + 3 * k));
			dev_now = 10'(group_value(frm, SFP_SPLIT_POS + 1));
			push_beat(SFP_CH_A, 1'b0, KIND_ACK, 1'b1);
			push_beat(SFP_CH_C, 1'b0, KIND_ACK, 1'b1);
			push_beat(SFP_CH_K, 1'b1, KIND_ACK, 1'b1);
		end else if (rx_depth >= 1 && recent_rx[SFP_HIST_LEN - 1] == SFP_CH_HASH &&
			cur == SFP_CH_QUERY) begin
			rep[0] = SFP_CH_HASH;
			for (k = 0; k < 4; k++) begin
				txt = decimal_text(addr_now[k]);
				for (j = 0; j < 3; j++)
					rep[1 + 3 * k + j] = txt[2 - j];
			end
			rep[SFP_SPLIT_POS] = SFP_CH_DOLLAR;
			txt = decimal_text(dev_now);
			for (j = 0; j < 3; j++)
				rep[SFP_SPLIT_POS + 1 + j] = txt[2 - j];
			rep[SFP_FRAME_LEN - 1] = SFP_CH_HASH;
			for (k = 0; k < SFP_FRAME_LEN; k++)
				push_beat(rep[k], k == SFP_FRAME_LEN - 1, KIND_REPORT, 1'b0);
		end
		for (k = 0; k < SFP_HIST_LEN - 1; k++)
			recent_rx[k] = recent_rx[k + 1];
		recent_rx[SFP_HIST_LEN - 1] = cur;
		if (rx_depth < SFP_HIST_LEN)
			rx_depth++;
	endfunction

	function automatic void check_field(input string what, input logic [9:0] want,
		input logic [9:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// stimulus building
	function automatic void add_byte(input logic [7:0] ch);
		rx_item_t it;
		it.ch     = ch;
		it.hold   = hold_next;
		hold_next = 1'b0;
		rx_backlog.push_back(it);
	endfunction

	function automatic void add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic logic [7:0] field_char();
		if ($urandom_range(0, 9) != 0)
			return SFP_CH_ZERO + 8'($urandom_range(0, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add_frame(input bit reuse_open, input bit broken);
		frame_t      body;
		int unsigned k;
		body[0] = SFP_CH_HASH;
		for (k = 1; k < SFP_FRAME_LEN - 1; k++)
			body[k] = field_char();
		body[SFP_SPLIT_POS] = SFP_CH_DOLLAR;
		body[SFP_FRAME_LEN - 1] = SFP_CH_HASH;
		if (broken) begin
			case ($urandom_range(0, 2))
				0: body[0] = 8'($urandom_range(0, 255));
				1: body[SFP_SPLIT_POS] = 8'($urandom_range(0, 255));
				default: body[SFP_FRAME_LEN - 1] = 8'($urandom_range(0, 255));
			endcase
		end
		for (k = reuse_open ? 1 : 0; k < SFP_FRAME_LEN; k++)
			add_byte(body[k]);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("settings_frame_parser_top verification failed");
		$finish;
	end

	// receive channel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid   <= 1'b0;
			rx_if.rx_char <= '0;
			rx_gap        <= 0;
		end else begin
			if (rx_if.valid && rx_if.ready)
				parse_rx_byte(rx_if.rx_char);
			if (!rx_if.valid || rx_if.ready) begin
				if (rx_gap != 0) begin
					rx_if.valid <= 1'b0;
					rx_gap      <= rx_gap - 1;
				end else if (rx_backlog.size() != 0 &&
					!(rx_backlog[0].hold && reply_due.size() != 0)) begin
					rx_if.valid   <= 1'b1;
					rx_if.rx_char <= rx_backlog[0].ch;
					void'(rx_backlog.pop_front());
					rx_gap <= rx_burst ? 0 : $urandom_range(0, 8);
					if ($urandom_range(0, 19) == 0)
						rx_burst <= !rx_burst;
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// reply channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_if.ready <= 1'b0;
			tx_stall    <= 0;
		end else if (tx_if.valid && tx_if.ready) begin
			if (reply_due.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual tx_char %0d",
					$time, tx_if.tx_char);
				mismatches++;
			end else begin
				seen = reply_due.pop_front();
				check_field("tx_char", seen.ch, tx_if.tx_char);
				check_field("run_end", seen.last, tx_if.run_end);
				check_field("reply_kind", seen.kind, tx_if.reply_kind);
				check_field("save_request", seen.save, tx_if.save_request);
				check_field("addr_first", seen.addr[0], tx_if.addr_first);
				check_field("addr_second", seen.addr[1], tx_if.addr_second);
				check_field("addr_third", seen.addr[2], tx_if.addr_third);
				check_field("addr_fourth", seen.addr[3], tx_if.addr_fourth);
				check_field("device_number", seen.dev, tx_if.device_number);
			end
			tx_draw = tx_burst ? 0 : $urandom_range(0, 8);
			if ($urandom_range(0, 19) == 0)
				tx_burst <= !tx_burst;
			if (tx_draw == 0) begin
				tx_if.ready <= 1'b1;
			end else begin
				tx_if.ready <= 1'b0;
				tx_stall    <= tx_draw - 1;
			end
		end else if (!tx_if.ready) begin
			if (tx_stall == 0)
				tx_if.ready <= 1'b1;
			else
				tx_stall <= tx_stall - 1;
		end
	end

	initial begin
		int unsigned k;
		bit          reuse;
		rx_if.valid   = 1'b0;
		rx_if.rx_char = '0;
		tx_if.ready   = 1'b0;
		arst_n        = 1'b0;
		rx_burst      = 1'b0;
		tx_burst      = 1'b0;
		mismatches    = 0;
		hold_next     = 1'b0;
		for (k = 0; k < SFP_HIST_LEN; k++)
			recent_rx[k] = '0;
		rx_depth = 0;
		addr_now = {SFP_RST_ADDR3, SFP_RST_ADDR2, SFP_RST_ADDR1, SFP_RST_ADDR0};
		dev_now  = SFP_RST_DEV;

		// directed: byte extremes, report of reset settings, a frame with
		// oversized groups and non-digits, then a query on its closing hash
		add_text("?");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("#?#999256007x12$9a5#?");
		hold_next = 1'b1;

		while (rx_backlog.size() < 370) begin
			if ($urandom_range(0, 24) == 0)
				hold_next = 1'b1;
			k = $urandom_range(0, 99);
			reuse = rx_backlog[$].ch == SFP_CH_HASH && $urandom_range(0, 1) == 1;
			if (k < 45) begin
				add_frame(reuse, 1'b0);
				if ($urandom_range(0, 3) == 0)
					add_byte(SFP_CH_QUERY);
			end else if (k < 60) begin
				add_frame(reuse, 1'b1);
			end else if (k < 80) begin
				repeat ($urandom_range(1, 4))
					add_text("#?");
			end else begin
				repeat ($urandom_range(1, 6))
					add_byte(8'($urandom_range(0, 255)));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (rx_backlog.size() != 0 || rx_if.valid)
			@(posedge clk);
		while (reply_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("settings_frame_parser_top verification clean");
		else
			$display("settings_frame_parser_top verification failed");
		$finish;
	end

endmodule
